@@ rtl/nisr_pkg.sv @@
// ----------------------------------------------------------------------------
// nisr_pkg: shared types and constants
// Register map, reset values and the command and status records that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package nisr_pkg;

    localparam int ITER_W = 6;
    localparam int TOL_W  = 8;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic REG_MAX_ITER = 1'b0;
    localparam logic REG_TOL      = 1'b1;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 6'd20;
    localparam logic [TOL_W-1:0]  TOL_RESET      = 8'd1;

    typedef struct packed {
        logic load;       // capture a new request and seed the iterate
        logic div_start;  // set up the serial divider for one step
        logic div_step;   // one quotient bit
        logic update;     // finish a Newton step
        logic out_load;   // move the iterate into the result register
    } t_dp_cmd;

    typedef struct packed {
        logic num_zero;   // captured number is zero
        logic finished;   // converged or cap reached
        logic div_last;   // the current division step is the final one
    } t_dp_sts;

endpackage

@@ rtl/nisr_in_if.sv @@
// ----------------------------------------------------------------------------
// nisr_in_if: request channel
// Valid/ready channel that carries the number and the starting guess.
// ----------------------------------------------------------------------------
interface nisr_in_if #(
    parameter int NUMBER_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic        [NUMBER_BITS-1:0] number;
    logic signed [NUMBER_BITS-1:0] initial_guess;

    modport source (output valid, number, initial_guess, input ready);
    modport sink   (input valid, number, initial_guess, output ready);
endinterface

@@ rtl/nisr_out_if.sv @@
// ----------------------------------------------------------------------------
// nisr_out_if: result channel
// Valid/ready channel that carries the computed root.
// ----------------------------------------------------------------------------
interface nisr_out_if #(
    parameter int NUMBER_BITS = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] root;

    modport source (output valid, root, input ready);
    modport sink   (input valid, root, output ready);
endinterface

@@ rtl/nisr_regs.sv @@
// ----------------------------------------------------------------------------
// nisr_regs: configuration registers
// APB-style register file holding the iteration cap and the tolerance.
// ----------------------------------------------------------------------------
module nisr_regs
    import nisr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [ITER_W-1:0] o_max_iter,
    output logic [TOL_W-1:0]  o_tol
);

    logic [ITER_W-1:0] r_max_iter;
    logic [TOL_W-1:0]  r_tol;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Registers are word aligned; the byte offset bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
            r_tol      <= TOL_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_MAX_ITER) begin
                r_max_iter <= pwdata[ITER_W-1:0];
            end else begin
                r_tol <= pwdata[TOL_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_TOL) begin
            prdata = {{(APB_DW-TOL_W){1'b0}}, r_tol};
        end else begin
            prdata = {{(APB_DW-ITER_W){1'b0}}, r_max_iter};
        end
    end

    assign o_max_iter = r_max_iter;
    assign o_tol      = r_tol;

endmodule

@@ rtl/nisr_dp.sv @@
// ----------------------------------------------------------------------------
// nisr_dp: Newton iteration datapath
// Holds the operand, the iterate and the step count, and divides the number
// by the iterate with a restoring divider that yields one bit per cycle.
// ----------------------------------------------------------------------------
module nisr_dp
    import nisr_pkg::*;
#(
    parameter int NUMBER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic        [NUMBER_BITS-1:0] i_number,
    input  logic signed [NUMBER_BITS-1:0] i_initial_guess,
    input  logic        [ITER_W-1:0]      i_max_iter,
    input  logic        [TOL_W-1:0]       i_tol,
    output logic        [NUMBER_BITS-1:0] o_root
);

    localparam int NB    = NUMBER_BITS;
    localparam int BIT_W = $clog2(NUMBER_BITS);

    logic [NB-1:0]     r_n;
    logic [NB-1:0]     r_x;
    logic [NB-1:0]     r_r;
    logic [NB-1:0]     r_quo;
    logic [NB:0]       r_rem;
    logic [BIT_W-1:0]  r_bit;
    logic [ITER_W-1:0] r_cnt;
    logic              r_done;
    logic [NB-1:0]     r_root;

    logic [NB-1:0] seed_mag;
    logic [NB-1:0] seed;
    logic [NB:0]   trial;
    logic          fits;
    logic [NB:0]   sum;
    logic [NB-1:0] n_r;
    logic [NB-1:0] diff;

    // The magnitude of the most negative guess comes out as the unsigned
    // value of its sign bit, which is what the two's complement negate gives.
    always_comb begin
        if (i_initial_guess[NB-1]) begin
            seed_mag = NB'(-i_initial_guess);
        end else begin
            seed_mag = NB'(i_initial_guess);
        end
        if (i_initial_guess == '0) begin
            seed = NB'(1);
        end else begin
            seed = seed_mag;
        end
    end

    // The iterate never reaches zero once the number is nonzero, so it is
    // used directly as the divisor.
    assign trial = {r_rem[NB-1:0], r_quo[NB-1]};
    assign fits  = (trial >= {1'b0, r_x});

    assign sum = {1'b0, r_x} + {1'b0, r_quo};
    assign n_r = sum[NB:1];

    always_comb begin
        if (n_r >= r_x) begin
            diff = n_r - r_x;
        end else begin
            diff = r_x - n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (i_cmd.update) begin
                r_cnt  <= r_cnt + ITER_W'(1);
                r_done <= (diff <= {{(NB-TOL_W){1'b0}}, i_tol});
            end
            if (i_cmd.div_start) begin
                r_bit <= BIT_W'(NUMBER_BITS - 1);
            end else if (i_cmd.div_step) begin
                r_bit <= r_bit - BIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_number;
            r_x <= seed;
            r_r <= '0;
        end else if (i_cmd.update) begin
            r_x <= n_r;
            r_r <= n_r;
        end
        if (i_cmd.div_start) begin
            r_quo <= r_n;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_rem <= trial - {1'b0, r_x};
            end else begin
                r_rem <= trial;
            end
            r_quo <= {r_quo[NB-2:0], fits};
        end
        if (i_cmd.out_load) begin
            r_root <= r_r;
        end
    end

    assign o_sts.num_zero = (r_n == '0);
    assign o_sts.finished = r_done || (r_cnt >= i_max_iter);
    assign o_sts.div_last = (r_bit == '0);
    assign o_root         = r_root;

endmodule

@@ rtl/nisr_ctrl.sv @@
// ----------------------------------------------------------------------------
// nisr_ctrl: Newton iteration controller
// Sequences seeding, serial division and update for each request, and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module nisr_ctrl
    import nisr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.num_zero || i_sts.finished) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_OUT: begin
                // Hold the finished root until the result register is free.
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted request did not move to the check state");

    a_div_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_UPD))
        else $error("last division step not followed by update");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && slot_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished root was not posted to the result register");

    a_no_load_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.out_load)
        else $error("result register overwritten while still pending");
`endif

endmodule

@@ rtl/newton_integer_square_root.sv @@
// ----------------------------------------------------------------------------
// newton_integer_square_root: Newton-Raphson integer square root
// Channel   Dir  Handshake     Payload
// i_in_ch   in   valid/ready   number, initial_guess
// o_out_ch  out  valid/ready   root
// apb       in   psel/penable  step cap @0x0, tolerance @0x4
//
// After a request is taken the controller runs at most the step cap of Newton
// steps; each runs the serial divider, one quotient bit per cycle, and then
// an update. The root is then posted, and the controller returns to idle,
// where the next request can be taken.
// The next request is taken while the result register still holds an untaken
// root. A stalled result holds the controller once its next root is ready.
// Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module newton_integer_square_root
    import nisr_pkg::*;
#(
    parameter int NUMBER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nisr_in_if.sink           i_in_ch,
    nisr_out_if.source        o_out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_dp_cmd                cmd;
    t_dp_sts                sts;
    logic [ITER_W-1:0]      max_iter;
    logic [TOL_W-1:0]       tol;
    logic [NUMBER_BITS-1:0] root;

    nisr_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_iter (max_iter),
        .o_tol      (tol)
    );

    nisr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    nisr_dp #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_number        (i_in_ch.number),
        .i_initial_guess (i_in_ch.initial_guess),
        .i_max_iter      (max_iter),
        .i_tol           (tol),
        .o_root          (root)
    );

    assign o_out_ch.root = root;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for newton_integer_square_root
// A table of directed requests covers the register extremes, zero inputs and
// seeds, and the most negative guess; random phases under several register
// settings follow. Each root is checked against its row or a Newton predictor.
// ----------------------------------------------------------------------------
module tb;
    import nisr_pkg::*;

    localparam int NB           = 16;
    localparam int STALL_LIMIT  = 6000;
    localparam int QUIET_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 220;
    localparam int ROWS         = 20;

    typedef struct {
        logic [ITER_W-1:0] iters;
        logic [TOL_W-1:0]  tol;
        logic [NB-1:0]     number;
        logic [NB-1:0]     guess;
        bit                given;
        logic [NB-1:0]     root;
    } t_directed_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    nisr_in_if  #(.NUMBER_BITS(NB)) in_ch ();
    nisr_out_if #(.NUMBER_BITS(NB)) out_ch ();

    newton_integer_square_root #(.NUMBER_BITS(NB)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Register copies used by the predictor.
    logic [ITER_W-1:0] iter_cap;
    logic [TOL_W-1:0]  step_tol;

    logic [NB-1:0] expected_roots [$];
    logic [NB-1:0] want_root;
    logic          pinned_given;
    logic [NB-1:0] pinned_root;
    bit            calm;
    int            error_count;
    int            requests_issued;
    int            roots_received;
    int            settings_applied;
    int            idle_cycles = 0;

    t_directed_row directed_rows [0:ROWS-1] = '{
        '{6'd20, 8'd1,   16'd0,     16'd123,   1'b1, 16'd0},
        '{6'd20, 8'd1,   16'd0,     16'd0,     1'b1, 16'd0},
        '{6'd20, 8'd1,   16'd1,     16'd0,     1'b1, 16'd1},
        '{6'd20, 8'd1,   16'd4,     16'hFFFE,  1'b1, 16'd2},
        '{6'd20, 8'd1,   16'd100,   16'hFFF6,  1'b1, 16'd10},
        '{6'd20, 8'd1,   16'hFFFF,  16'd255,   1'b1, 16'd256},
        '{6'd20, 8'd1,   16'hFFFF,  16'h8000,  1'b0, 16'd0},
        '{6'd20, 8'd1,   16'hFFFF,  16'h7FFF,  1'b0, 16'd0},
        '{6'd20, 8'd1,   16'hFFFF,  16'hFFFF,  1'b0, 16'd0},
        '{6'd20, 8'd1,   16'd1,     16'h8000,  1'b0, 16'd0},
        '{6'd20, 8'd1,   16'hAAAA,  16'h5555,  1'b0, 16'd0},
        '{6'd1,  8'd0,   16'hFFFF,  16'd1,     1'b1, 16'd32768},
        '{6'd1,  8'd0,   16'd100,   16'd0,     1'b1, 16'd50},
        '{6'd63, 8'd0,   16'd8,     16'd3,     1'b0, 16'd0},
        '{6'd63, 8'd0,   16'hFFFF,  16'h8000,  1'b0, 16'd0},
        '{6'd0,  8'd1,   16'd100,   16'd7,     1'b1, 16'd0},
        '{6'd0,  8'd1,   16'hFFFF,  16'hFFFF,  1'b1, 16'd0},
        '{6'd63, 8'd255, 16'd50000, 16'd1,     1'b0, 16'd0},
        '{6'd63, 8'd255, 16'h5555,  16'hAAAA,  1'b0, 16'd0},
        '{6'd20, 8'd1,   16'd2,     16'd1,     1'b0, 16'd0}
    };

    logic [ITER_W-1:0] phase_iters [0:PHASES-1] = '{6'd20, 6'd1, 6'd63, 6'd63,
                                                    6'd5, 6'd12, 6'd40, 6'd7};
    logic [TOL_W-1:0]  phase_tol   [0:PHASES-1] = '{8'd1, 8'd0, 8'd0, 8'd255,
                                                    8'd3, 8'd0, 8'd2, 8'd128};
    bit                phase_calm  [0:PHASES-1] = '{1'b0, 1'b0, 1'b0, 1'b1,
                                                    1'b0, 1'b0, 1'b0, 1'b1};

    // Newton iteration on the magnitude of the guess; stops on a small step
    // or when the step cap is used up.
    function automatic logic [NB-1:0] newton_root(input logic [NB-1:0] number,
                                                  input logic [NB-1:0] guess,
                                                  input logic [ITER_W-1:0] cap,
                                                  input logic [TOL_W-1:0] tol);
        logic [31:0] x;
        logic [31:0] r;
        logic [31:0] delta;
        int unsigned steps;
        bit          settled;
        r       = '0;
        steps   = 0;
        settled = 1'b0;
        if (number == '0) begin
            return '0;
        end
        // The most negative guess negates to itself, which is its magnitude.
        x = {16'd0, guess[NB-1] ? (~guess + 16'd1) : guess};
        if (guess == '0) begin
            x = 32'd1;
        end
        while (steps < cap && !settled) begin
            if (x == 0) begin
                x = 32'd1;
            end
            r     = (x + number / x) >> 1;
            delta = (r > x) ? (r - x) : (x - r);
            if (delta <= tol) begin
                settled = 1'b1;
            end
            x = r;
            steps++;
        end
        return r[NB-1:0];
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure per root.
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Scoreboard and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_roots.push_back(pinned_given ? pinned_root :
                    newton_root(in_ch.number, in_ch.initial_guess, iter_cap, step_tol));
            end
            if (out_ch.valid && out_ch.ready) begin
                roots_received++;
                if (expected_roots.size() == 0) begin
                    $error("root: no request outstanding, actual %0d", out_ch.root);
                    error_count++;
                end else begin
                    want_root = expected_roots.pop_front();
                    if (out_ch.root !== want_root) begin
                        $error("root: expected %0d, actual %0d", want_root, out_ch.root);
                        error_count++;
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (psel && penable && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Each access ends with the bus returned to idle so that back-to-back accesses
    // never drive the bus twice in one time step.
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        apb_access(1'b0, {idx, 2'b00}, '0, got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d",
                   idx == REG_MAX_ITER ? "step_cap" : "tolerance", want, got);
            error_count++;
        end
    endtask

    task automatic write_register(input logic idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] unused;
        apb_access(1'b1, {idx, 2'b00}, value, unused);
        if (idx == REG_MAX_ITER) begin
            iter_cap = value[ITER_W-1:0];
        end else begin
            step_tol = value[TOL_W-1:0];
        end
        check_register(idx, value);
    endtask

    // Lower valid and wait until every issued request has returned its root.
    task automatic drain(input int extra);
        in_ch.valid <= 1'b0;
        while (roots_received < requests_issued) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [ITER_W-1:0] iters,
                                 input logic [TOL_W-1:0] tol);
        drain(QUIET_CYCLES);
        write_register(REG_MAX_ITER, APB_DW'(iters));
        write_register(REG_TOL, APB_DW'(tol));
        settings_applied++;
    endtask

    task automatic send_request(input logic [NB-1:0] number, input logic [NB-1:0] guess,
                                input bit given, input logic [NB-1:0] root);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.number        <= number;
        in_ch.initial_guess <= guess;
        pinned_given        <= given;
        pinned_root         <= root;
        do @(posedge i_clk); while (!in_ch.ready);
        requests_issued++;
    endtask

    // Biased toward zero, the top of the range, small values, squares and
    // their neighbors, and guesses that are zero, most negative, or small.
    task automatic random_request(output logic [NB-1:0] number,
                                  output logic [NB-1:0] guess);
        int unsigned pick;
        int unsigned k;
        int unsigned mag;
        pick = $urandom_range(0, 7);
        case (pick)
            0: number = '0;
            1: number = 16'hFFFF - 16'($urandom_range(0, 3));
            2, 3: number = 16'($urandom_range(1, 255));
            4, 5: begin
                k      = $urandom_range(1, 255);
                number = 16'(k * k + $urandom_range(0, 2) - 1);
            end
            default: number = 16'($urandom);
        endcase
        pick = $urandom_range(0, 7);
        case (pick)
            0: guess = '0;
            1: guess = 16'h8000;
            2, 3: begin
                mag   = $urandom_range(1, 300);
                guess = $urandom_range(0, 1) ? 16'(0 - mag) : 16'(mag);
            end
            default: guess = 16'($urandom);
        endcase
    endtask

    initial begin
        logic [NB-1:0] number;
        logic [NB-1:0] guess;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.number        <= '0;
        in_ch.initial_guess <= '0;
        pinned_given        <= 1'b0;
        pinned_root         <= '0;
        calm             = 1'b0;
        error_count      = 0;
        requests_issued  = 0;
        roots_received   = 0;
        settings_applied = 0;
        iter_cap         = MAX_ITER_RESET;
        step_tol         = TOL_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_register(REG_MAX_ITER, APB_DW'(MAX_ITER_RESET));
        check_register(REG_TOL, APB_DW'(TOL_RESET));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].iters != iter_cap || directed_rows[i].tol != step_tol) begin
                apply_setting(directed_rows[i].iters, directed_rows[i].tol);
            end
            send_request(directed_rows[i].number, directed_rows[i].guess,
                         directed_rows[i].given, directed_rows[i].root);
        end

        for (int p = 0; p < PHASES; p++) begin
            apply_setting(phase_iters[p], phase_tol[p]);
            calm = phase_calm[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_request(number, guess);
                send_request(number, guess, 1'b0, '0);
            end
        end
        calm = 1'b0;
        drain(20);

        $display("Ran %0d requests under %0d register settings; %0d roots compared.",
                 requests_issued, settings_applied, roots_received);
        $display("Step caps from 0 to 63 and tolerances from 0 to 255 were exercised.");
        if (error_count == 0 && expected_roots.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
